@@ rtl/core/grdt_pkg.sv @@
// Shared types and constants for the Gaussian row filter with 2:1 decimation.
// Used by the channel interfaces, the cell modules and the top level.
`default_nettype none
package grdt_pkg;

   localparam int TAP_RADIUS_DEF = 5;
   localparam int MAX_WIDTH_DEF  = 4096;
   localparam int MAX_HEIGHT_DEF = 4096;

   localparam int PIX_W      = 16;
   localparam int COEF_W     = 16;
   localparam int COEF_NUM   = 6;
   localparam int DIM_W      = 13;
   localparam int DIM_CAP    = 8191;
   localparam int MIN_WIDTH  = 6;
   localparam int OUT_ROW_W  = 11;
   localparam int OUT_COL_W  = 12;
   localparam int PAIR_W     = PIX_W + 1;
   localparam int PROD_W     = PAIR_W + COEF_W;
   localparam int ACC_W      = 36;
   localparam int FRAC_W     = 16;
   localparam int ROUND_HALF = 32768;
   localparam int FIFO_DEPTH = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int XW         = 15;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ROW_WIDTH    = 3'd0,
      REG_IMAGE_HEIGHT = 3'd1,
      REG_COEF_CENTER  = 3'd2,
      REG_COEF_DIST1   = 3'd3,
      REG_COEF_DIST2   = 3'd4,
      REG_COEF_DIST3   = 3'd5,
      REG_COEF_DIST4   = 3'd6,
      REG_COEF_DIST5   = 3'd7
   } csr_index_type;

   localparam logic [COEF_W-1:0] COEF_RESET [COEF_NUM] =
      '{16'd16346, 16'd13449, 16'd7485, 16'd2819, 16'd718, 16'd124};

   typedef struct packed {
      logic [OUT_ROW_W-1:0] out_row;
      logic [OUT_COL_W-1:0] out_col;
      logic                 row_done;
      logic                 frame_done;
   } result_meta_type;

   typedef struct packed {
      logic [PIX_W-1:0] value;
      result_meta_type  meta;
   } result_type;

endpackage
`default_nettype wire

@@ rtl/core/grdt_if.sv @@
// Channel interfaces: pixel input, filtered result output and register writes.
// Depends on grdt_pkg for field widths.
`default_nettype none
interface grdt_req_if;
   import grdt_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_in;
   modport source (output valid, output pixel_in, input ready);
   modport sink (input valid, input pixel_in, output ready);
endinterface

interface grdt_rsp_if;
   import grdt_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [PIX_W-1:0]     value;
   logic [OUT_ROW_W-1:0] out_row;
   logic [OUT_COL_W-1:0] out_col;
   logic                 row_done;
   logic                 frame_done;
   modport source (output valid, output value, output out_row, output out_col,
                   output row_done, output frame_done, input ready);
   modport sink (input valid, input value, input out_row, input out_col,
                 input row_done, input frame_done, output ready);
endinterface

interface grdt_csr_if;
   import grdt_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/grdt_cell.sv @@
// One cell of the pixel window: holds a pixel and passes it on when shift is high.
// Depends on grdt_pkg for the pixel width.
`default_nettype none
module grdt_cell (
   input  logic                       clock,
   input  logic                       shift,
   input  logic [grdt_pkg::PIX_W-1:0] pixel_in,
   output logic [grdt_pkg::PIX_W-1:0] pixel_out
);
   import grdt_pkg::*;

   logic [PIX_W-1:0] pixel_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         pixel_ff <= pixel_in;
      end
   end

   assign pixel_out = pixel_ff;
endmodule
`default_nettype wire

@@ rtl/core/grdt_mac.sv @@
// Weight cell: multiplies a folded tap pair by its coefficient, registered.
// Depends on grdt_pkg for operand widths.
`default_nettype none
module grdt_mac (
   input  logic                        clock,
   input  logic [grdt_pkg::PAIR_W-1:0] pair_in,
   input  logic [grdt_pkg::COEF_W-1:0] coef_in,
   output logic [grdt_pkg::PROD_W-1:0] prod_out
);
   import grdt_pkg::*;

   logic [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(pair_in) * PROD_W'(coef_in);
   end

   assign prod_out = prod_ff;
endmodule
`default_nettype wire

@@ rtl/core/grdt_fifo.sv @@
// Result queue that decouples the filter pipeline from the output channel.
// Depends on grdt_pkg for the result type and depth.
`default_nettype none
module grdt_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  grdt_pkg::result_type    push_data,
   input  logic                    pop,
   output logic                    out_valid,
   output grdt_pkg::result_type    out_data
);
   import grdt_pkg::*;

   localparam int PW = $clog2(FIFO_DEPTH);
   localparam int CW = $clog2(FIFO_DEPTH + 1);

   result_type    mem_ff [FIFO_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
endmodule
`default_nettype wire

@@ rtl/core/gaussian_row_decimate_transpose.sv @@
// Gaussian row filter with 2:1 decimation and transposed result coordinates.
// Depends on grdt_pkg, grdt_if, grdt_cell, grdt_mac and grdt_fifo.
//
// Usage: pixels enter on req_bus in raster order, one beat per pixel. Each row
// is filtered by a symmetric (2*TAP_RADIUS+1)-tap kernel with mirrored borders,
// and every even column yields one beat on rsp_bus with out_row = column/2 and
// out_col = source row. row_done marks the last beat of a row, frame_done the
// last beat of the frame. Registers are written on csr_bus, which is always
// ready; write them only while the block is idle.
// Throughput: one pixel per cycle while req ready is high. After the last
// pixel of a row req ready stays low while the block computes the right
// border columns from the held window.
// A result passes the pair, product and partial-sum registers, then the queue.
// Results pass through an 8-entry queue; a credit counter holds req ready low
// when every queue slot is promised, so a stalled receiver backs up into the
// input without losing results.
// Reset clears counters and the queue, fills credits, sets register defaults.
`default_nettype none
module gaussian_row_decimate_transpose #(
   parameter int TAP_RADIUS = grdt_pkg::TAP_RADIUS_DEF,
   parameter int MAX_WIDTH  = grdt_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = grdt_pkg::MAX_HEIGHT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   grdt_req_if.sink    req_bus,
   grdt_rsp_if.source  rsp_bus,
   grdt_csr_if.sink    csr_bus
);
   import grdt_pkg::*;

   localparam int WIN   = 2 * TAP_RADIUS + 1;
   localparam int NCOEF = TAP_RADIUS + 1;
   localparam int HALF  = (NCOEF + 1) / 2;
   localparam int FW    = $clog2(TAP_RADIUS + 1);
   localparam int CRW   = $clog2(FIFO_DEPTH + 1);
   localparam int WCAP  = (MAX_WIDTH < DIM_CAP) ? MAX_WIDTH : DIM_CAP;
   localparam int HCAP  = (MAX_HEIGHT < DIM_CAP) ? MAX_HEIGHT : DIM_CAP;

   // Configuration registers.
   logic [DIM_W-1:0]  row_width_ff;
   logic [DIM_W-1:0]  image_height_ff;
   logic [COEF_W-1:0] coef_ff [COEF_NUM];

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff    <= DIM_W'(640);
         image_height_ff <= DIM_W'(480);
         for (int n = 0; n < COEF_NUM; n++) begin
            coef_ff[n] <= COEF_RESET[n];
         end
      end else if (csr_bus.valid) begin
         case (csr_index_type'(csr_bus.index))
            REG_ROW_WIDTH:    row_width_ff    <= csr_bus.data[DIM_W-1:0];
            REG_IMAGE_HEIGHT: image_height_ff <= csr_bus.data[DIM_W-1:0];
            REG_COEF_CENTER:  coef_ff[0]      <= csr_bus.data;
            REG_COEF_DIST1:   coef_ff[1]      <= csr_bus.data;
            REG_COEF_DIST2:   coef_ff[2]      <= csr_bus.data;
            REG_COEF_DIST3:   coef_ff[3]      <= csr_bus.data;
            REG_COEF_DIST4:   coef_ff[4]      <= csr_bus.data;
            REG_COEF_DIST5:   coef_ff[5]      <= csr_bus.data;
            default: ;
         endcase
      end
   end

   assign csr_bus.ready = 1'b1;

   // Frame position and clamped dimensions.
   logic [DIM_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [DIM_W-1:0] w_eff, h_eff, c_cur, r_cur;
   logic             last_col, last_row;

   always_comb begin
      if (row_width_ff < DIM_W'(MIN_WIDTH)) w_eff = DIM_W'(MIN_WIDTH);
      else if (row_width_ff > DIM_W'(WCAP)) w_eff = DIM_W'(WCAP);
      else w_eff = row_width_ff;
      if (image_height_ff == '0) h_eff = DIM_W'(1);
      else if (image_height_ff > DIM_W'(HCAP)) h_eff = DIM_W'(HCAP);
      else h_eff = image_height_ff;
      // A counter left beyond a shrunk size ends its row or frame.
      c_cur    = (col_ff >= w_eff) ? w_eff - DIM_W'(1) : col_ff;
      r_cur    = (row_ff >= h_eff) ? h_eff - DIM_W'(1) : row_ff;
      last_col = (c_cur == w_eff - DIM_W'(1));
      last_row = (r_cur == h_eff - DIM_W'(1));
   end

   // Credits count queue slots not yet promised to a result in flight.
   logic [CRW-1:0] credit_ff, credit_in;
   logic           have_credit, accept, issue, pop;

   // Border flush state, loaded by the last pixel of a row.
   logic [FW-1:0]          flush_cnt_ff, flush_cnt_in;
   logic signed [XW-1:0]   flush_x_ff, flush_x_in;
   logic [DIM_W-1:0]       flush_c_ff, flush_c_in;
   logic [DIM_W-1:0]       flush_row_ff, flush_row_in;
   logic                   flush_last_ff, flush_last_in;
   logic                   flush_active, flush_step;

   assign have_credit   = (credit_ff != '0);
   assign flush_active  = (flush_cnt_ff != '0);
   assign req_bus.ready = have_credit && !flush_active;
   assign accept        = req_bus.valid && req_bus.ready;
   assign flush_step    = flush_active && have_credit;

   // Window: a chain of cells, newest pixel in cell zero.
   logic [PIX_W-1:0] win_q    [WIN];
   logic [PIX_W-1:0] win_next [WIN];
   logic [PIX_W-1:0] win_src  [WIN];

   for (genvar g = 0; g < WIN; g++) begin : g_win
      if (g == 0) begin : g_head
         assign win_next[g] = req_bus.pixel_in;
      end else begin : g_body
         assign win_next[g] = win_q[g-1];
      end
      grdt_cell u_cell (
         .clock     (clock),
         .shift     (accept),
         .pixel_in  (win_next[g]),
         .pixel_out (win_q[g])
      );
      // The flush reads the held window; a new beat reads the shifted one.
      assign win_src[g] = flush_active ? win_q[g] : win_next[g];
   end

   // Column to filter in this cycle.
   logic signed [XW-1:0] x_acc, sel_x, sel_c;
   logic [DIM_W-1:0]     sel_row;
   logic                 sel_end, sel_last_row;
   result_meta_type      s0_meta;

   always_comb begin
      x_acc        = $signed({2'b00, c_cur}) - $signed(XW'(TAP_RADIUS));
      sel_x        = flush_active ? flush_x_ff : x_acc;
      sel_c        = flush_active ? $signed({2'b00, flush_c_ff}) : $signed({2'b00, c_cur});
      sel_row      = flush_active ? flush_row_ff : r_cur;
      sel_end      = flush_active ? 1'b1 : last_col;
      sel_last_row = flush_active ? flush_last_ff : last_row;
      issue        = accept ? (!x_acc[XW-1] && !x_acc[0]) : (flush_step && !flush_x_ff[0]);
      s0_meta.out_row    = sel_x[OUT_ROW_W:1];
      s0_meta.out_col    = sel_row[OUT_COL_W-1:0];
      // The last even column of a row carries row_done.
      s0_meta.row_done   = sel_end && (sel_x == {sel_c[XW-1:1], 1'b0});
      s0_meta.frame_done = s0_meta.row_done && sel_last_row;
   end

   // Tap selection with mirrored borders, then folding of symmetric pairs.
   logic signed [XW-1:0] tap_j [WIN];
   logic signed [XW-1:0] tap_k [WIN];
   logic [PIX_W-1:0]     tap   [WIN];
   logic [PAIR_W-1:0]    pair  [NCOEF];

   always_comb begin
      for (int i = 0; i < WIN; i++) begin
         tap_j[i] = sel_x + $signed(XW'(i)) - $signed(XW'(TAP_RADIUS));
         if (tap_j[i] < 0) begin
            tap_j[i] = XW'(-tap_j[i] - 1);
         end else if (tap_j[i] > sel_c) begin
            tap_j[i] = XW'((sel_c <<< 1) - tap_j[i] + 1);
         end
         tap_k[i] = sel_c - tap_j[i];
         tap[i]   = '0;
         for (int m = 0; m < WIN; m++) begin
            if (tap_k[i] == $signed(XW'(m))) begin
               tap[i] = win_src[m];
            end
         end
      end
      pair[0] = {1'b0, tap[TAP_RADIUS]};
      for (int d = 1; d < NCOEF; d++) begin
         pair[d] = {1'b0, tap[TAP_RADIUS-d]} + {1'b0, tap[TAP_RADIUS+d]};
      end
   end

   // Control state update.
   always_comb begin
      col_in        = col_ff;
      row_in        = row_ff;
      flush_cnt_in  = flush_cnt_ff;
      flush_x_in    = flush_x_ff;
      flush_c_in    = flush_c_ff;
      flush_row_in  = flush_row_ff;
      flush_last_in = flush_last_ff;
      if (accept) begin
         if (last_col) begin
            col_in        = '0;
            row_in        = last_row ? '0 : r_cur + DIM_W'(1);
            flush_cnt_in  = FW'(TAP_RADIUS);
            flush_x_in    = x_acc + $signed(XW'(1));
            flush_c_in    = c_cur;
            flush_row_in  = r_cur;
            flush_last_in = last_row;
         end else begin
            col_in = c_cur + DIM_W'(1);
            row_in = r_cur;
         end
      end else if (flush_step) begin
         flush_cnt_in = flush_cnt_ff - FW'(1);
         flush_x_in   = flush_x_ff + $signed(XW'(1));
      end
      credit_in = credit_ff - CRW'(issue) + CRW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         flush_cnt_ff <= '0;
         credit_ff    <= CRW'(FIFO_DEPTH);
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         flush_cnt_ff <= flush_cnt_in;
         credit_ff    <= credit_in;
      end
   end

   always_ff @(posedge clock) begin
      flush_x_ff    <= flush_x_in;
      flush_c_ff    <= flush_c_in;
      flush_row_ff  <= flush_row_in;
      flush_last_ff <= flush_last_in;
   end

   // Stage 1: folded pairs. Stage 2: products. Stage 3: partial sums.
   logic              s1_valid_ff, s2_valid_ff, s3_valid_ff;
   result_meta_type   s1_meta_ff, s2_meta_ff, s3_meta_ff;
   logic [PAIR_W-1:0] s1_pair_ff [NCOEF];
   logic [PROD_W-1:0] s2_prod    [NCOEF];
   logic [ACC_W-1:0]  s3_lo_in, s3_hi_in, s3_lo_ff, s3_hi_ff;

   for (genvar d = 0; d < NCOEF; d++) begin : g_mac
      grdt_mac u_mac (
         .clock    (clock),
         .pair_in  (s1_pair_ff[d]),
         .coef_in  (coef_ff[d]),
         .prod_out (s2_prod[d])
      );
   end

   always_comb begin
      s3_lo_in = '0;
      s3_hi_in = '0;
      for (int d = 0; d < NCOEF; d++) begin
         if (d < HALF) s3_lo_in = s3_lo_in + ACC_W'(s2_prod[d]);
         else s3_hi_in = s3_hi_in + ACC_W'(s2_prod[d]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int d = 0; d < NCOEF; d++) begin
         s1_pair_ff[d] <= pair[d];
      end
      s1_meta_ff <= s0_meta;
      s2_meta_ff <= s1_meta_ff;
      s3_meta_ff <= s2_meta_ff;
      s3_lo_ff   <= s3_lo_in;
      s3_hi_ff   <= s3_hi_in;
   end

   // Final add, round half up and saturate on the way into the queue.
   logic [ACC_W-1:0]        acc_total;
   logic [ACC_W-FRAC_W-1:0] acc_round;
   result_type              push_data, out_data;

   always_comb begin
      acc_total = s3_lo_ff + s3_hi_ff + ACC_W'(ROUND_HALF);
      acc_round = acc_total[ACC_W-1:FRAC_W];
      push_data.value = (|acc_round[ACC_W-FRAC_W-1:PIX_W]) ? '1 : acc_round[PIX_W-1:0];
      push_data.meta  = s3_meta_ff;
   end

   assign pop = rsp_bus.valid && rsp_bus.ready;

   grdt_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s3_valid_ff),
      .push_data (push_data),
      .pop       (pop),
      .out_valid (rsp_bus.valid),
      .out_data  (out_data)
   );

   assign rsp_bus.value      = out_data.value;
   assign rsp_bus.out_row    = out_data.meta.out_row;
   assign rsp_bus.out_col    = out_data.meta.out_col;
   assign rsp_bus.row_done   = out_data.meta.row_done;
   assign rsp_bus.frame_done = out_data.meta.frame_done;

   // Credits never exceed the queue depth.
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= CRW'(FIFO_DEPTH))
      else $error("credit counter above queue depth");

   // A queued result means at least one credit is out.
   a_credit_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (credit_ff < CRW'(FIFO_DEPTH)))
      else $error("result visible without a credit taken");

   // The last pixel of a row starts the border flush.
   a_flush_start: assert property (@(posedge clock) disable iff (reset)
      (accept && last_col) |=> (flush_cnt_ff == FW'(TAP_RADIUS)))
      else $error("border flush not started at row end");

   // frame_done only ever comes with row_done.
   a_frame_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.frame_done) |-> rsp_bus.row_done)
      else $error("frame_done without row_done");

endmodule
`default_nettype wire

@@ test/grdt_tb_scoreboard.sv @@
// Scoreboard for the Gaussian row filter testbench: a bit-exact predictor of
// the filtered, decimated results and a queue of the results still owed.
// Depends on grdt_pkg for field widths and register indexes.
`timescale 1ns / 100ps
class grdt_blur_scoreboard;
   localparam int RADIUS = 5;
   localparam int WIN = 2 * RADIUS + 1;

   logic [12:0] width_reg;
   logic [12:0] height_reg;
   logic [15:0] weight [6];
   logic [15:0] window [WIN];
   int unsigned col_next;
   int unsigned row_next;
   grdt_pkg::result_type owed [$];
   int errors;

   function new();
      width_reg = 13'd640;
      height_reg = 13'd480;
      for (int i = 0; i < 6; i++) weight[i] = grdt_pkg::COEF_RESET[i];
      for (int i = 0; i < WIN; i++) window[i] = '0;
      col_next = 0;
      row_next = 0;
      errors = 0;
   endfunction

   function void write_reg(grdt_pkg::csr_index_type idx, logic [15:0] data);
      case (idx)
         grdt_pkg::REG_ROW_WIDTH: width_reg = data[12:0];
         grdt_pkg::REG_IMAGE_HEIGHT: height_reg = data[12:0];
         default: weight[int'(idx) - int'(grdt_pkg::REG_COEF_CENTER)] = data;
      endcase
   endfunction

   // Filter column x of the row whose newest pixel sits at column c.
   function logic [15:0] blur_at(int x, int c, int w);
      longint unsigned acc;
      int j;
      int k;
      int d;
      acc = 0;
      for (int i = -RADIUS; i <= RADIUS; i++) begin
         j = x + i;
         d = (i < 0) ? -i : i;
         if (j < 0) j = -j - 1;
         if (j >= w) j = 2 * w - j - 1;
         k = c - j;
         if (k >= 0 && k < WIN) acc += longint'(window[k]) * longint'(weight[d]);
      end
      acc = (acc + 32768) >> 16;
      if (acc > 65535) acc = 65535;
      return acc[15:0];
   endfunction

   // Notes one accepted pixel and queues the results it causes.
   function void note_pixel(logic [15:0] pix);
      int w;
      int h;
      int c;
      int r;
      int lastx;
      bit last_col;
      bit last_row;
      int n;
      grdt_pkg::result_type item;
      w = int'(width_reg);
      h = int'(height_reg);
      if (w < 6) w = 6;
      if (w > 4096) w = 4096;
      if (h < 1) h = 1;
      if (h > 4096) h = 4096;
      c = (col_next >= w) ? w - 1 : col_next;
      r = (row_next >= h) ? h - 1 : row_next;
      last_col = (c == w - 1);
      last_row = (r == h - 1);
      for (int k = WIN - 1; k > 0; k--) window[k] = window[k - 1];
      window[0] = pix;
      lastx = last_col ? c : c - RADIUS;
      n = 0;
      for (int x = c - RADIUS; x <= lastx; x++) begin
         if (x >= 0 && x % 2 == 0) begin
            item.value = blur_at(x, c, w);
            item.meta.out_row = 11'(x >> 1);
            item.meta.out_col = 12'(r);
            item.meta.row_done = 1'b0;
            item.meta.frame_done = 1'b0;
            owed = {owed, item};
            n++;
         end
      end
      if (last_col && n > 0) begin
         owed[$].meta.row_done = 1'b1;
         owed[$].meta.frame_done = last_row;
      end
      if (last_col) begin
         col_next = 0;
         row_next = last_row ? 0 : r + 1;
      end else begin
         col_next = c + 1;
         row_next = r;
      end
   endfunction

   task report(string what, int got, int want);
      $display("mismatch: %s got %0d want %0d", what, got, want);
      errors++;
   endtask

   task check_result(grdt_pkg::result_type got);
      grdt_pkg::result_type want;
      if (owed.size() == 0) begin
         report("unexpected result beat, value", got.value, -1);
      end else begin
         want = owed.pop_front();
         if (got.value !== want.value) report("value", got.value, want.value);
         if (got.meta.out_row !== want.meta.out_row)
            report("out_row", got.meta.out_row, want.meta.out_row);
         if (got.meta.out_col !== want.meta.out_col)
            report("out_col", got.meta.out_col, want.meta.out_col);
         if (got.meta.row_done !== want.meta.row_done)
            report("row_done", got.meta.row_done, want.meta.row_done);
         if (got.meta.frame_done !== want.meta.frame_done)
            report("frame_done", got.meta.frame_done, want.meta.frame_done);
      end
   endtask
endclass

@@ test/tb_gaussian_row_decimate_transpose.sv @@
// Top-level testbench for the Gaussian row filter with 2:1 decimation.
// Depends on grdt_pkg, grdt_if, the block itself and grdt_tb_scoreboard.
`timescale 1ns / 100ps
module tb_gaussian_row_decimate_transpose;
   import grdt_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit stim_done = 1'b0;
   bit sink_stalls = 1'b1;

   grdt_req_if req_bus ();
   grdt_rsp_if rsp_bus ();
   grdt_csr_if csr_bus ();

   gaussian_row_decimate_transpose dut (
      .clock(clock), .reset(reset),
      .req_bus(req_bus), .rsp_bus(rsp_bus), .csr_bus(csr_bus)
   );

   grdt_blur_scoreboard blur_board = new();

   always #10 clock = ~clock;

   // Mostly short gaps, now and then a long one.
   function int gap_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Random pixel: mostly uniform, sometimes at one of the two extremes so the
   // accumulator is pushed toward saturation.
   function logic [15:0] random_pixel();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return 16'h0000;
      if (roll == 1) return 16'hFFFF;
      return 16'($urandom_range(0, 65535));
   endfunction

   initial begin
      req_bus.valid = 1'b0;
      req_bus.pixel_in = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = REG_ROW_WIDTH;
      csr_bus.data = '0;
   end

   // One pixel beat: valid is held until the block takes it, and the model
   // learns the pixel at the same edge the block does. Without a gap, valid
   // simply stays high into the next beat.
   task send_pixel(logic [15:0] pix);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.pixel_in <= pix;
      do @(posedge clock); while (!req_bus.ready);
      blur_board.note_pixel(pix);
   endtask

   // One register beat, after which valid is dropped.
   task write_reg(csr_index_type idx, logic [15:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= data;
      do @(posedge clock); while (!csr_bus.ready);
      blur_board.write_reg(idx, data);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Wait until every owed result has arrived, then let the border flush of
   // a row and the pipeline settle before any write.
   task drain();
      req_bus.valid <= 1'b0;
      while (blur_board.owed.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task send_frame_rows(int rows, int w);
      for (int i = 0; i < rows * w; i++) send_pixel(random_pixel());
   endtask

   // Receiver: ready toggles with random gaps, and results are checked at the
   // edge where valid and ready are both high.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         blur_board.check_result({rsp_bus.value, rsp_bus.out_row, rsp_bus.out_col,
                                  rsp_bus.row_done, rsp_bus.frame_done});
   end

   initial begin
      int hold;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!sink_stalls) begin
            rsp_bus.ready <= 1'b1;
         end else if (hold > 0) begin
            hold--;
         end else if (rsp_bus.ready) begin
            hold = gap_length();
            if (hold > 0) rsp_bus.ready <= 1'b0;
            else hold = $urandom_range(0, 6);
         end else begin
            rsp_bus.ready <= 1'b1;
            hold = $urandom_range(0, 8);
         end
      end
   end

   initial begin
      int w;
      int h;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: a 6-wide, 2-row frame with reset weights and extreme pixels.
      write_reg(REG_ROW_WIDTH, 16'd6);
      write_reg(REG_IMAGE_HEIGHT, 16'd2);
      for (int i = 0; i < 6; i++) send_pixel((i % 2) ? 16'hFFFF : 16'h0000);
      for (int i = 0; i < 6; i++) send_pixel(16'hFFFF);
      drain();

      // Unnormalized full-scale weights saturate; a width below the minimum is
      // clamped to six and a zero height to one row.
      write_reg(REG_COEF_CENTER, 16'hFFFF);
      write_reg(REG_COEF_DIST1, 16'hFFFF);
      write_reg(REG_COEF_DIST2, 16'hFFFF);
      write_reg(REG_COEF_DIST3, 16'hFFFF);
      write_reg(REG_COEF_DIST4, 16'hFFFF);
      write_reg(REG_COEF_DIST5, 16'hFFFF);
      write_reg(REG_ROW_WIDTH, 16'd0);
      write_reg(REG_IMAGE_HEIGHT, 16'd0);
      for (int i = 0; i < 12; i++) send_pixel(16'hFFFF);
      drain();

      // Zero weights, a 7-wide frame: one full row and six pixels of the next,
      // which leaves the counters at column six of row one.
      for (int i = 0; i < 6; i++)
         write_reg(csr_index_type'(int'(REG_COEF_CENTER) + i), 16'h0000);
      write_reg(REG_ROW_WIDTH, 16'd7);
      write_reg(REG_IMAGE_HEIGHT, 16'd3);
      for (int i = 0; i < 13; i++) send_pixel((i % 2) ? 16'h8000 : 16'h1234);
      drain();

      // Shrink the sizes mid-frame: counters beyond the new sizes end the row
      // and the frame at once.
      write_reg(REG_COEF_CENTER, 16'd16346);
      write_reg(REG_ROW_WIDTH, 16'd6);
      write_reg(REG_IMAGE_HEIGHT, 16'd1);
      send_pixel(16'hABCD);
      drain();

      // Random phases: small frames with random weights (reset weights in the first), mostly short rows.
      for (int phase = 0; phase < 10; phase++) begin
         w = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 40) : $urandom_range(6, 12);
         h = $urandom_range(1, 3);
         write_reg(REG_ROW_WIDTH, 16'(w));
         write_reg(REG_IMAGE_HEIGHT, 16'(h));
         for (int i = 0; i < 6; i++)
            write_reg(csr_index_type'(int'(REG_COEF_CENTER) + i),
                      (phase == 0) ? COEF_RESET[i] : 16'($urandom_range(0, 65535)));
         send_frame_rows(h, w);
         if (phase == 3) begin
            // Receiver stalls are off from this drain through the next phase's pixels.
            sink_stalls = 1'b0;
         end else begin
            sink_stalls = 1'b1;
         end
         drain();
      end

      // A 4096-wide frame with only a short stretch of its first row.
      write_reg(REG_ROW_WIDTH, 16'd4096);
      write_reg(REG_IMAGE_HEIGHT, 16'd4096);
      for (int i = 0; i < 40; i++) send_pixel(random_pixel());
      drain();
      stim_done = 1'b1;
   end

   initial begin
      wait (stim_done);
      repeat (50) @(posedge clock);
      if (blur_board.errors == 0 && blur_board.owed.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end
endmodule

@@ sim.f @@
rtl/core/grdt_pkg.sv
rtl/core/grdt_if.sv
rtl/core/grdt_cell.sv
rtl/core/grdt_mac.sv
rtl/core/grdt_fifo.sv
rtl/core/gaussian_row_decimate_transpose.sv
test/grdt_tb_scoreboard.sv
test/tb_gaussian_row_decimate_transpose.sv
